/* design/dhsd_pkg.sv */
// shared types and constants of the delimited hex sample deframer
// no dependencies
`default_nettype none

package dhsd_pkg;

  localparam int unsigned MaxBodyBytes = 64;
  localparam int unsigned BodyLenW     = $clog2(MaxBodyBytes + 1);
  localparam int unsigned MinTrigChars = 4;
  localparam int unsigned MaxTrigChars = 8;
  localparam int unsigned DataChars    = 16;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QPtrW        = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW        = $clog2(QueueDepth + 1);
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 64;

  typedef enum logic [1:0] {
    KindTrigger   = 2'd0,
    KindData      = 2'd1,
    KindMalformed = 2'd2,
    KindBad       = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDelimiter   = 2'd0,
    CfgTrigPattern = 2'd1,
    CfgTrigLength  = 2'd2
  } cfg_idx_e;

  // classified receive beat
  typedef struct packed {
    logic       delim;
    logic       hex;
    logic [3:0] nibble;
    logic [7:0] data;
  } beat_t;

  // live trigger settings handed to the parser
  typedef struct packed {
    logic [63:0] pattern;
    logic [3:0]  length;
  } trig_cfg_t;

endpackage

`default_nettype wire

/* design/dhsd_rx_if.sv */
// receive byte channel: valid, ready and one byte of payload
// no dependencies
`default_nettype none

interface dhsd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* design/dhsd_res_if.sv */
// frame result channel: valid, ready, frame kind, samples and counters
// no dependencies
`default_nettype none

interface dhsd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_kind;
  logic [31:0] first_sample;
  logic [31:0] second_sample;
  logic [31:0] triggers_seen;
  logic [31:0] malformed_seen;
  logic [31:0] bad_seen;

  modport source (output valid, output frame_kind, output first_sample,
                  output second_sample, output triggers_seen,
                  output malformed_seen, output bad_seen, input ready);
  modport sink (input valid, input frame_kind, input first_sample,
                input second_sample, input triggers_seen,
                input malformed_seen, input bad_seen, output ready);
endinterface

`default_nettype wire

/* design/dhsd_front.sv */
// front end: accepts receive beats and classifies them (delimiter, hex digit)
// depends on dhsd_pkg and dhsd_rx_if
`default_nettype none

module dhsd_front (
  dhsd_rx_if.sink        rx,
  input  wire logic [7:0] delim_i,
  input  wire logic      q_ready_i,
  output logic           q_push_o,
  output dhsd_pkg::beat_t q_beat_o
);
  import dhsd_pkg::*;

  logic [7:0] b;

  assign b        = rx.rx_byte;
  assign rx.ready = q_ready_i;
  assign q_push_o = rx.valid & q_ready_i;

  always_comb begin
    q_beat_o.delim  = (b == delim_i);
    q_beat_o.data   = b;
    q_beat_o.hex    = 1'b1;
    q_beat_o.nibble = 4'd0;
    priority if (b >= 8'h30 && b <= 8'h39) begin
      q_beat_o.nibble = 4'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      q_beat_o.nibble = 4'(b - 8'h37);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      q_beat_o.nibble = 4'(b - 8'h57);
    end else begin
      q_beat_o.hex = 1'b0;
    end
  end

endmodule

`default_nettype wire

/* design/dhsd_queue.sv */
// short queue of classified beats between front end and parser
// depends on dhsd_pkg
`default_nettype none

module dhsd_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  dhsd_pkg::beat_t      push_beat_i,
  output logic                 push_ready_o,
  input  wire logic            pop_i,
  output logic                 pop_valid_o,
  output dhsd_pkg::beat_t      pop_beat_o
);
  import dhsd_pkg::*;

  beat_t            mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  function automatic logic [QPtrW-1:0] ptr_next(input logic [QPtrW-1:0] p);
    ptr_next = (p == QPtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ready_o = (cnt_q != QCntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_beat_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + QCntW'(push_i) - QCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_beat_i;
    end
  end

endmodule

`default_nettype wire

/* design/dhsd_back.sv */
// parser: frame state, trigger and hex checks, counters and result register
// depends on dhsd_pkg and dhsd_res_if
`default_nettype none

module dhsd_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  dhsd_pkg::beat_t    q_beat_i,
  output logic               q_pop_o,
  input  dhsd_pkg::trig_cfg_t trig_cfg_i,
  dhsd_res_if.source         res
);
  import dhsd_pkg::*;

  logic                in_frame_q, in_frame_d;
  logic [BodyLenW-1:0] len_q, len_d;
  logic [63:0]         acc_q, acc_d;
  logic                all_hex_q, all_hex_d;
  logic                prefix_q, prefix_d;
  logic [31:0]         trig_cnt_q, trig_cnt_d;
  logic [31:0]         mal_cnt_q, mal_cnt_d;
  logic [31:0]         bad_cnt_q, bad_cnt_d;

  logic                out_valid_q;
  kind_e               out_kind_q, out_kind_d;
  logic [63:0]         out_word_q, out_word_d;
  logic [31:0]         out_trig_q, out_mal_q, out_bad_q;

  logic                emit;
  logic                take;
  logic [3:0]          tlen;
  logic [2:0]          pos;
  logic [7:0]          pat_byte;

  assign take    = !out_valid_q || res.ready;
  assign q_pop_o = q_valid_i && take;

  assign tlen     = (trig_cfg_i.length > 4'(MaxTrigChars)) ? 4'(MaxTrigChars)
                                                           : trig_cfg_i.length;
  assign pos      = len_q[2:0];
  assign pat_byte = trig_cfg_i.pattern[{~pos, 3'b000} +: 8];

  always_comb begin
    in_frame_d = in_frame_q;
    len_d      = len_q;
    acc_d      = acc_q;
    all_hex_d  = all_hex_q;
    prefix_d   = prefix_q;
    trig_cnt_d = trig_cnt_q;
    mal_cnt_d  = mal_cnt_q;
    bad_cnt_d  = bad_cnt_q;
    emit       = 1'b0;
    out_kind_d = KindMalformed;
    out_word_d = '0;
    if (q_pop_o) begin
      priority if (!in_frame_q) begin
        if (q_beat_i.delim) begin
          in_frame_d = 1'b1;
          len_d      = '0;
          acc_d      = '0;
          all_hex_d  = 1'b1;
          prefix_d   = 1'b1;
        end
      end else if (q_beat_i.delim) begin
        emit      = 1'b1;
        len_d     = '0;
        acc_d     = '0;
        all_hex_d = 1'b1;
        prefix_d  = 1'b1;
        priority if (len_q >= BodyLenW'(MinTrigChars) && prefix_q) begin
          out_kind_d = KindTrigger;
          trig_cnt_d = trig_cnt_q + 32'd1;
        end else if (len_q == BodyLenW'(DataChars) && all_hex_q) begin
          out_kind_d = KindData;
          out_word_d = acc_q;
        end else begin
          mal_cnt_d = mal_cnt_q + 32'd1;
        end
      end else if (len_q >= BodyLenW'(MaxBodyBytes)) begin
        // body too long: report and wait for the next delimiter
        emit       = 1'b1;
        out_kind_d = KindBad;
        in_frame_d = 1'b0;
        len_d      = '0;
        acc_d      = '0;
        all_hex_d  = 1'b1;
        prefix_d   = 1'b1;
        bad_cnt_d  = bad_cnt_q + 32'd1;
      end else begin
        if (len_q >= BodyLenW'(tlen) || q_beat_i.data != pat_byte) begin
          prefix_d = 1'b0;
        end
        if (q_beat_i.hex) begin
          acc_d = {acc_q[59:0], q_beat_i.nibble};
        end else begin
          all_hex_d = 1'b0;
        end
        len_d = len_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      len_q       <= '0;
      acc_q       <= '0;
      all_hex_q   <= 1'b1;
      prefix_q    <= 1'b1;
      trig_cnt_q  <= '0;
      mal_cnt_q   <= '0;
      bad_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
      len_q      <= len_d;
      acc_q      <= acc_d;
      all_hex_q  <= all_hex_d;
      prefix_q   <= prefix_d;
      trig_cnt_q <= trig_cnt_d;
      mal_cnt_q  <= mal_cnt_d;
      bad_cnt_q  <= bad_cnt_d;
      if (take) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_kind_q <= out_kind_d;
      out_word_q <= out_word_d;
      out_trig_q <= trig_cnt_d;
      out_mal_q  <= mal_cnt_d;
      out_bad_q  <= bad_cnt_d;
    end
  end

  assign res.valid          = out_valid_q;
  assign res.frame_kind     = out_kind_q;
  assign res.first_sample   = out_word_q[63:32];
  assign res.second_sample  = out_word_q[31:0];
  assign res.triggers_seen  = out_trig_q;
  assign res.malformed_seen = out_mal_q;
  assign res.bad_seen       = out_bad_q;

endmodule

`default_nettype wire

/* design/delimited_hex_sample_deframer.sv */
// top level: configuration registers, front end, beat queue and parser
// depends on dhsd_pkg, dhsd_rx_if, dhsd_res_if, dhsd_front, dhsd_queue, dhsd_back
// throughput: one received beat per cycle; a waiting result stalls the parser and the
// two-entry queue then fills and holds off the input
// a closing delimiter's beat is stored in the beat queue and its result then in the result register
// reset: asynchronous, clears frame state, counters and queue; no clearing pass
`default_nettype none

module delimited_hex_sample_deframer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  dhsd_rx_if.sink                            rx_i,
  dhsd_res_if.source                         res_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [dhsd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [dhsd_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import dhsd_pkg::*;

  logic [7:0]  delim_q;
  logic [63:0] pattern_q;
  logic [3:0]  tlen_q;

  logic        q_push;
  logic        q_ready;
  beat_t       q_push_beat;
  logic        q_pop;
  logic        q_valid;
  beat_t       q_pop_beat;
  trig_cfg_t   trig_cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q   <= 8'h24;
      pattern_q <= '0;
      tlen_q    <= 4'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDelimiter:   delim_q   <= cfg_wdata_i[7:0];
        CfgTrigPattern: pattern_q <= cfg_wdata_i[63:0];
        CfgTrigLength:  tlen_q    <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  assign trig_cfg.pattern = pattern_q;
  assign trig_cfg.length  = tlen_q;

  dhsd_front u_front (
    .rx        (rx_i),
    .delim_i   (delim_q),
    .q_ready_i (q_ready),
    .q_push_o  (q_push),
    .q_beat_o  (q_push_beat)
  );

  dhsd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_beat_i  (q_push_beat),
    .push_ready_o (q_ready),
    .pop_i        (q_pop),
    .pop_valid_o  (q_valid),
    .pop_beat_o   (q_pop_beat)
  );

  dhsd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_beat_i   (q_pop_beat),
    .q_pop_o    (q_pop),
    .trig_cfg_i (trig_cfg),
    .res        (res_o)
  );

endmodule

`default_nettype wire

/* sim/delimited_hex_sample_deframer_test.sv */
`timescale 1ns / 1ps
// self-checking bench for delimited_hex_sample_deframer: streams of good and broken frames
// go in, each frame result is checked against an in-bench frame parser
// depends on dhsd_pkg, dhsd_rx_if, dhsd_res_if and the deframer rtl

module delimited_hex_sample_deframer_test;
  import dhsd_pkg::*;

  localparam int unsigned RandomBytes    = 900;
  localparam int unsigned PhaseBytes     = 130;
  localparam int unsigned SettleCycles   = 8;
  localparam int unsigned SinkHoldCycles = 300;
  localparam int unsigned WatchdogLimit  = 2000;

  typedef struct {
    logic       drain_wait;
    logic [7:0] data;
  } rx_slot_t;

  typedef struct {
    kind_e       kind;
    logic [31:0] first_sample;
    logic [31:0] second_sample;
    logic [31:0] triggers_seen;
    logic [31:0] malformed_seen;
    logic [31:0] bad_seen;
  } frame_res_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  cfg_idx_e            cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  dhsd_rx_if  rx_ch ();
  dhsd_res_if res_ch ();

  delimited_hex_sample_deframer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .rx_i        (rx_ch),
    .res_o       (res_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // parser copy of the block
  logic [7:0]  m_delim         = 8'd36;
  logic [63:0] m_pattern       = '0;
  logic [3:0]  m_tlen          = 4'd4;
  logic        in_body         = 1'b0;
  int unsigned body_len        = 0;
  logic [63:0] digit_acc       = '0;
  logic        all_hex         = 1'b1;
  logic        trig_match      = 1'b1;
  logic [31:0] trig_total      = '0;
  logic [31:0] malformed_total = '0;
  logic [31:0] bad_total       = '0;

  frame_res_t  pending_frames[$];
  rx_slot_t    tx_bytes[$];

  int unsigned error_count   = 0;
  int unsigned stim_bytes    = 0;
  int unsigned send_idle_pct = 30;
  int unsigned sink_idle_pct = 30;
  int unsigned send_gap      = 0;
  int unsigned sink_gap      = 0;
  int unsigned hold_left     = 0;
  int unsigned stall_cycles  = 0;
  logic        hold_wanted   = 1'b0;
  logic        hold_started  = 1'b0;
  logic        rx_fire       = 1'b0;
  logic        res_fire      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void clear_body();
    body_len   = 0;
    digit_acc  = '0;
    all_hex    = 1'b1;
    trig_match = 1'b1;
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    frame_res_t  r;
    logic        have_res;
    int unsigned tlen;
    logic [7:0]  folded;
    have_res        = 1'b0;
    r.kind          = KindMalformed;
    r.first_sample  = '0;
    r.second_sample = '0;
    if (!in_body) begin
      if (b == m_delim) begin
        in_body = 1'b1;
        clear_body();
      end
    end else if (b == m_delim) begin
      have_res = 1'b1;
      if (body_len >= MinTrigChars && trig_match) begin
        trig_total++;
        r.kind = KindTrigger;
      end else if (body_len == DataChars && all_hex) begin
        r.kind          = KindData;
        r.first_sample  = digit_acc[63:32];
        r.second_sample = digit_acc[31:0];
      end else begin
        malformed_total++;
      end
      clear_body();
    end else if (body_len >= MaxBodyBytes) begin
      // body too long: drop it and hunt for the next delimiter
      have_res = 1'b1;
      in_body  = 1'b0;
      clear_body();
      bad_total++;
      r.kind = KindBad;
    end else begin
      tlen = (m_tlen > MaxTrigChars) ? MaxTrigChars : m_tlen;
      if (body_len >= tlen || m_pattern[63 - 8*body_len -: 8] != b) trig_match = 1'b0;
      folded = b | 8'h20;
      if (b >= 8'h30 && b <= 8'h39) digit_acc = {digit_acc[59:0], b[3:0]};
      else if (folded >= 8'h61 && folded <= 8'h66) digit_acc = {digit_acc[59:0], b[3:0] + 4'd9};
      else all_hex = 1'b0;
      body_len++;
    end
    if (have_res) begin
      r.triggers_seen  = trig_total;
      r.malformed_seen = malformed_total;
      r.bad_seen       = bad_total;
      pending_frames.push_back(r);
    end
  endfunction

  function automatic int unsigned next_gap(int unsigned pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r >= pct) return 0;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib, logic upper);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want_v);
    error_count++;
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want_v);
  endtask

  task automatic push_byte(logic [7:0] b);
    rx_slot_t s;
    s.drain_wait = 1'b0;
    s.data       = b;
    tx_bytes.push_back(s);
    stim_bytes++;
  endtask

  task automatic push_drain_wait();
    rx_slot_t s;
    s.drain_wait = 1'b1;
    s.data       = '0;
    tx_bytes.push_back(s);
  endtask

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // hex body of n_chars digits taken from word, one byte replaced at spoil_at if it lies in the body
  task automatic push_hex_frame(logic [63:0] word, int unsigned n_chars, int unsigned spoil_at);
    for (int unsigned i = 0; i < n_chars; i++) begin
      if (i == spoil_at) push_byte(8'($urandom));
      else push_byte(hex_char(word[63 - 4*(i % 16) -: 4], 1'($urandom)));
    end
    push_byte(m_delim);
  endtask

  task automatic push_trigger_frame(int unsigned n);
    int unsigned spoil_at;
    spoil_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : n;
    for (int unsigned k = 0; k < n; k++) begin
      if (k >= MaxTrigChars || k == spoil_at) push_byte(8'($urandom));
      else push_byte(m_pattern[63 - 8*k -: 8]);
    end
    push_byte(m_delim);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgDelimiter:   m_delim   = value[7:0];
      CfgTrigPattern: m_pattern = value;
      CfgTrigLength:  m_tlen    = value[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain_stream();
    while (tx_bytes.size() != 0 || rx_ch.valid || pending_frames.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // byte driver
  always @(negedge clk) begin
    rx_slot_t slot;
    if (!rst_n) begin
      rx_ch.valid <= 1'b0;
    end else if (!rx_ch.valid || rx_fire) begin
      if (send_gap != 0) begin
        rx_ch.valid <= 1'b0;
        send_gap    <= send_gap - 1;
      end else if (tx_bytes.size() == 0) begin
        rx_ch.valid <= 1'b0;
      end else if (tx_bytes[0].drain_wait) begin
        rx_ch.valid <= 1'b0;
        if (pending_frames.size() == 0) slot = tx_bytes.pop_front();
      end else begin
        slot           = tx_bytes.pop_front();
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= slot.data;
        send_gap      <= next_gap(send_idle_pct);
      end
    end
  end

  // result sink with random stalls and one long hold
  always @(negedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else if (hold_wanted && !hold_started) begin
      hold_started <= 1'b1;
      hold_left    <= SinkHoldCycles;
      res_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else if (sink_gap != 0) begin
      sink_gap     <= sink_gap - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
      if (res_fire || $urandom_range(0, 15) == 0) sink_gap <= next_gap(sink_idle_pct);
    end
  end

  // monitor: check result beats, feed accepted byte beats to the parser copy
  always @(posedge clk) begin
    frame_res_t want;
    if (!rst_n) begin
      rx_fire  <= 1'b0;
      res_fire <= 1'b0;
    end else begin
      rx_fire  <= rx_ch.valid && rx_ch.ready;
      res_fire <= res_ch.valid && res_ch.ready;
      if (res_ch.valid && res_ch.ready) begin
        if (pending_frames.size() == 0) begin
          flag_mismatch("result with no frame pending", 32'(res_ch.frame_kind), '0);
        end else begin
          want = pending_frames.pop_front();
          if (res_ch.frame_kind !== want.kind)
            flag_mismatch("frame_kind", 32'(res_ch.frame_kind), 32'(want.kind));
          if (res_ch.first_sample !== want.first_sample)
            flag_mismatch("first_sample", res_ch.first_sample, want.first_sample);
          if (res_ch.second_sample !== want.second_sample)
            flag_mismatch("second_sample", res_ch.second_sample, want.second_sample);
          if (res_ch.triggers_seen !== want.triggers_seen)
            flag_mismatch("triggers_seen", res_ch.triggers_seen, want.triggers_seen);
          if (res_ch.malformed_seen !== want.malformed_seen)
            flag_mismatch("malformed_seen", res_ch.malformed_seen, want.malformed_seen);
          if (res_ch.bad_seen !== want.bad_seen)
            flag_mismatch("bad_seen", res_ch.bad_seen, want.bad_seen);
        end
      end
      if (rx_ch.valid && rx_ch.ready) deframe_byte(rx_ch.rx_byte);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned phase_end;
    int unsigned pick;
    logic [7:0]  new_delim;
    logic [63:0] new_pattern;
    logic [3:0]  new_len;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CfgDelimiter;
    cfg_wdata     = '0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    res_ch.ready  = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: junk before the first delimiter, empty body, zero trigger
    push_byte(8'h00);
    push_byte(8'hFF);
    push_str("A$$");
    repeat (4) push_byte(8'h00);
    push_byte(m_delim);
    drain_stream();

    write_reg(CfgTrigPattern, "TRIGGER!");
    write_reg(CfgTrigLength, 64'd6);
    push_str("0123456789ABCDEF$fedcba9876543210$FFFFFFFF00000000$");
    push_str("TRIG$TRIGGE$TRIGGER$TRI$TRIGX$");
    // characters just outside the hex ranges
    push_str("0/9:A@FGa");
    push_byte(8'h60);
    push_str("fg0000$");
    push_str("0123456789ABCDE$0123456789ABCDEF0$");
    repeat (66) push_byte("a");
    push_str("zz$");
    drain_stream();

    // back pressure: sink holds off while bytes keep coming
    send_idle_pct = 0;
    sink_idle_pct = 0;
    hold_wanted  <= 1'b1;
    repeat (30) begin
      push_byte(m_delim);
      push_trigger_frame(MinTrigChars);
    end
    drain_stream();

    phase = 0;
    while (stim_bytes < RandomBytes) begin
      case (phase % 3)
        0: begin send_idle_pct = 0; sink_idle_pct = 0; end
        1: begin send_idle_pct = 35; sink_idle_pct = 35; end
        default: begin send_idle_pct = 60; sink_idle_pct = 20; end
      endcase
      case (phase % 7)
        0: begin new_delim = 8'd36; new_pattern = "TRIGGER!"; new_len = 4'd8; end
        1: begin new_delim = 8'h00; new_pattern = '1; new_len = 4'd4; end
        2: begin new_delim = 8'hFF; new_pattern = '0; new_len = 4'd15; end
        3: begin new_delim = "#"; new_pattern = {$urandom, $urandom}; new_len = 4'd3; end
        4: begin
          new_delim   = 8'($urandom);
          new_pattern = {$urandom, $urandom};
          new_len     = 4'($urandom);
        end
        5: begin new_delim = "$"; new_pattern = "C0FFEE12"; new_len = 4'd5; end
        default: begin new_delim = ":"; new_pattern = "SYNCWORD"; new_len = 4'd0; end
      endcase
      write_reg(CfgDelimiter, 64'(new_delim));
      write_reg(CfgTrigPattern, new_pattern);
      write_reg(CfgTrigLength, 64'(new_len));

      phase_end = stim_bytes + PhaseBytes;
      while (stim_bytes < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          push_hex_frame({$urandom, $urandom}, DataChars, DataChars);
        end else if (pick < 55) begin
          push_trigger_frame($urandom_range(3, 9));
        end else if (pick < 66) begin
          repeat ($urandom_range(0, 20)) push_byte(8'($urandom));
          push_byte(m_delim);
        end else if (pick < 78) begin
          push_hex_frame({$urandom, $urandom}, $urandom_range(15, 17), $urandom_range(0, 20));
        end else if (pick < 86) begin
          // unterminated noise that runs into the next body
          repeat ($urandom_range(1, 8)) push_byte(8'($urandom));
        end else if (pick < 90) begin
          repeat ($urandom_range(65, 70)) push_byte(hex_char(4'($urandom), 1'b1));
          repeat ($urandom_range(0, 4)) push_byte(8'($urandom));
          push_byte(m_delim);
        end else if (pick < 93) begin
          push_drain_wait();
        end else begin
          push_byte(m_delim);
        end
      end
      drain_stream();
      phase++;
    end

    if (error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
